/* hw/rtl/mouse_click_classifier_assert.svh */
// ---------------------------------------------------------------------------
// mouse click classifier assertion macros
// shared property forms for the click classifier checks
// ---------------------------------------------------------------------------
`ifndef MOUSE_CLICK_CLASSIFIER_ASSERT_SVH
`define MOUSE_CLICK_CLASSIFIER_ASSERT_SVH

// same-cycle implication on the block clock, quiet during reset
`define MCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on the block clock, quiet during reset
`define MCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mcc_pkg.sv */
// ---------------------------------------------------------------------------
// mcc_pkg
// types and constants shared by the mouse click classifier
// ---------------------------------------------------------------------------
package mcc_pkg;

	localparam int CMD_W   = 2;
	localparam int TIME_W  = 32;
	localparam int BTN_W   = 3;
	localparam int DELAY_W = 16;
	localparam int REG_IDX_W = 1;

	// event kinds
	localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd3;

	// report kinds
	localparam logic RPT_PRESSED  = 1'b0;
	localparam logic RPT_RELEASED = 1'b1;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_DOUBLE_DELAY = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_DELAY   = 1'b1;

	localparam logic [DELAY_W-1:0] DOUBLE_DELAY_RESET = 16'd300;
	localparam logic [DELAY_W-1:0] HOLD_DELAY_RESET   = 16'd1000;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [TIME_W-1:0] time_stamp;
		logic [BTN_W-1:0]  button_number;
	} evt_t;

	typedef struct packed {
		logic             report_kind;
		logic [BTN_W-1:0] reported_button;
		logic             double_mark;
		logic             hold_mark;
	} rpt_t;

	typedef struct packed {
		logic [DELAY_W-1:0] double_click_delay;
		logic [DELAY_W-1:0] hold_click_delay;
	} cfg_t;

endpackage

/* hw/rtl/mcc_evt_if.sv */
// ---------------------------------------------------------------------------
// mcc_evt_if
// mouse event channel: valid/ready with command, time stamp and button
// ---------------------------------------------------------------------------
interface mcc_evt_if;
	import mcc_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [TIME_W-1:0] time_stamp;
	logic [BTN_W-1:0]  button_number;

	modport source (output valid, command, time_stamp, button_number, input ready);
	modport sink   (input valid, command, time_stamp, button_number, output ready);
endinterface

/* hw/rtl/mcc_rpt_if.sv */
// ---------------------------------------------------------------------------
// mcc_rpt_if
// button report channel: valid/ready with kind, button and marks
// ---------------------------------------------------------------------------
interface mcc_rpt_if;
	import mcc_pkg::*;

	logic             valid;
	logic             ready;
	logic             report_kind;
	logic [BTN_W-1:0] reported_button;
	logic             double_mark;
	logic             hold_mark;

	modport source (output valid, report_kind, reported_button, double_mark, hold_mark,
		input ready);
	modport sink   (input valid, report_kind, reported_button, double_mark, hold_mark,
		output ready);
endinterface

/* hw/rtl/mcc_cfg_if.sv */
// ---------------------------------------------------------------------------
// mcc_cfg_if
// register write channel: valid/ready with register index and write data
// ---------------------------------------------------------------------------
interface mcc_cfg_if;
	import mcc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [DELAY_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/mcc_cfg_regs.sv */
// ---------------------------------------------------------------------------
// mcc_cfg_regs
// double click and hold delay registers behind the write channel
// ---------------------------------------------------------------------------
module mcc_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	mcc_cfg_if.sink       cfg,
	output mcc_pkg::cfg_t delays
);
	import mcc_pkg::*;

	cfg_t delays_q;

	// writes are always taken
	assign cfg.ready = 1'b1;
	assign delays    = delays_q;

	// register file, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delays_q.double_click_delay <= DOUBLE_DELAY_RESET;
			delays_q.hold_click_delay   <= HOLD_DELAY_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_DOUBLE_DELAY: delays_q.double_click_delay <= cfg.data;
				REG_HOLD_DELAY:   delays_q.hold_click_delay   <= cfg.data;
				default: begin
				end
			endcase
		end
	end
endmodule

/* hw/rtl/mcc_engine.sv */
// ---------------------------------------------------------------------------
// mcc_engine
// click state and single-pass classification of one registered event
// ---------------------------------------------------------------------------
module mcc_engine #(
	parameter int BUTTON_COUNT = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  mcc_pkg::evt_t item,
	input  logic          fire,
	input  mcc_pkg::cfg_t delays,
	output logic          has_result,
	output mcc_pkg::rpt_t result
);
	import mcc_pkg::*;

	localparam logic [BTN_W:0] BTN_LIMIT = (BTN_W+1)'(BUTTON_COUNT);

	logic [BUTTON_COUNT-1:0] held_mask_q, double_mask_q, hold_mask_q;
	logic [BUTTON_COUNT-1:0] held_mask_d, double_mask_d, hold_mask_d;
	logic                    clicked_q, clicked_d;
	logic [BTN_W-1:0]        last_button_q, last_button_d;
	logic [TIME_W-1:0]       first_click_time_q, first_click_time_d;
	logic [TIME_W-1:0]       last_event_time_q, last_event_time_d;

	logic [BUTTON_COUNT-1:0] btn_oh, last_oh;
	logic                    in_range;
	logic [TIME_W:0]         t_ext, double_lim, hold_lim;

	// one-hot decode of the event button and the last button
	always_comb begin
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			btn_oh[i]  = (item.button_number == BTN_W'(i));
			last_oh[i] = (last_button_q == BTN_W'(i));
		end
	end

	assign in_range   = ({1'b0, item.button_number} < BTN_LIMIT);
	assign t_ext      = {1'b0, item.time_stamp};
	assign double_lim = {1'b0, first_click_time_q} + (TIME_W+1)'(delays.double_click_delay);
	assign hold_lim   = {1'b0, last_event_time_q} + (TIME_W+1)'(delays.hold_click_delay);

	// classify the event and work out the next state
	always_comb begin
		held_mask_d        = held_mask_q;
		double_mask_d      = double_mask_q;
		hold_mask_d        = hold_mask_q;
		clicked_d          = clicked_q;
		last_button_d      = last_button_q;
		first_click_time_d = first_click_time_q;
		last_event_time_d  = last_event_time_q;
		has_result         = 1'b0;
		result.report_kind     = RPT_PRESSED;
		result.reported_button = item.button_number;
		result.double_mark     = 1'b0;
		result.hold_mark       = 1'b0;
		case (item.command)
			CMD_PRESS: begin
				if (in_range) begin
					if ((held_mask_q & btn_oh) == '0) begin
						held_mask_d = held_mask_q | btn_oh;
						if (clicked_q && item.button_number == last_button_q &&
								t_ext < double_lim) begin
							double_mask_d      = double_mask_q | btn_oh;
							result.double_mark = 1'b1;
						end else begin
							clicked_d          = 1'b0;
							first_click_time_d = item.time_stamp;
							last_button_d      = item.button_number;
						end
					end
					last_event_time_d = item.time_stamp;
					has_result        = item_valid;
				end
			end
			CMD_RELEASE: begin
				if (in_range) begin
					if (item.button_number == last_button_q && !clicked_q) begin
						clicked_d = 1'b1;
					end else begin
						clicked_d     = 1'b0;
						last_button_d = '0;
					end
					last_event_time_d  = item.time_stamp;
					result.report_kind = RPT_RELEASED;
					result.double_mark = |(double_mask_q & btn_oh);
					result.hold_mark   = |(hold_mask_q & btn_oh);
					held_mask_d        = held_mask_q & ~btn_oh;
					double_mask_d      = double_mask_q & ~btn_oh;
					hold_mask_d        = hold_mask_q & ~btn_oh;
					has_result         = item_valid;
				end
			end
			CMD_MOVE: begin
				clicked_d         = 1'b0;
				last_event_time_d = item.time_stamp;
			end
			CMD_TICK: begin
				// hold detection only while the last button is still down
				if ((held_mask_q & last_oh) != '0) begin
					if (t_ext > double_lim) begin
						clicked_d = 1'b0;
					end
					if (t_ext > hold_lim) begin
						last_event_time_d      = item.time_stamp;
						hold_mask_d            = hold_mask_q | last_oh;
						result.reported_button = last_button_q;
						result.hold_mark       = 1'b1;
						has_result             = item_valid;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// state update once the event leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_mask_q        <= '0;
			double_mask_q      <= '0;
			hold_mask_q        <= '0;
			clicked_q          <= 1'b0;
			last_button_q      <= '0;
			first_click_time_q <= '0;
			last_event_time_q  <= '0;
		end else if (fire) begin
			held_mask_q        <= held_mask_d;
			double_mask_q      <= double_mask_d;
			hold_mask_q        <= hold_mask_d;
			clicked_q          <= clicked_d;
			last_button_q      <= last_button_d;
			first_click_time_q <= first_click_time_d;
			last_event_time_q  <= last_event_time_d;
		end
	end
endmodule

/* hw/rtl/mouse_click_classifier.sv */
// Mouse click classifier: takes time-stamped press, release, move and tick
// events and gives at most one button report per event, marked double click
// or hold. One event is taken every clock cycle unless a report is stalled;
// each event is held in the input register, where it is classified against
// the click state and updates it, and its report is then loaded into the
// output register and shown from there. The engine state updates as each event
// leaves the input register, one event a cycle; a stalled report slot holds
// back only events that produce a report.
// ---------------------------------------------------------------------------
// mouse_click_classifier
// top level: input register, click engine, output register, delay registers
// ---------------------------------------------------------------------------
module mouse_click_classifier #(
	parameter int BUTTON_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	mcc_evt_if.sink    evt,
	mcc_rpt_if.source  rpt,
	mcc_cfg_if.sink    cfg
);
	import mcc_pkg::*;

	logic  evt_v_s1;
	evt_t  evt_s1;
	logic  rpt_v_q;
	rpt_t  rpt_q;
	cfg_t  delays;
	logic  has_result;
	rpt_t  result;
	logic  out_free;
	logic  s1_fire;

	mcc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.delays (delays)
	);

	mcc_engine #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (evt_v_s1),
		.item       (evt_s1),
		.fire       (s1_fire),
		.delays     (delays),
		.has_result (has_result),
		.result     (result)
	);

	// an item leaves the input register unless its report has nowhere to go
	assign out_free  = !rpt_v_q || rpt.ready;
	assign s1_fire   = evt_v_s1 && (!has_result || out_free);
	assign evt.ready = !evt_v_s1 || s1_fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_v_s1 <= 1'b0;
		end else if (evt.ready) begin
			evt_v_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1.command       <= evt.command;
			evt_s1.time_stamp    <= evt.time_stamp;
			evt_s1.button_number <= evt.button_number;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_v_q <= 1'b0;
		end else if (s1_fire && has_result) begin
			rpt_v_q <= 1'b1;
		end else if (rpt.ready) begin
			rpt_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && has_result) begin
			rpt_q <= result;
		end
	end

	assign rpt.valid           = rpt_v_q;
	assign rpt.report_kind     = rpt_q.report_kind;
	assign rpt.reported_button = rpt_q.reported_button;
	assign rpt.double_mark     = rpt_q.double_mark;
	assign rpt.hold_mark       = rpt_q.hold_mark;

	`include "mouse_click_classifier_assert.svh"

	// a classified item with a report always lands in the output register
	`MCC_ASSERT_NEXT(a_report_lands, s1_fire && has_result, rpt_v_q, "report lost")
	// an accepted event is always held in the input register next cycle
	`MCC_ASSERT_NEXT(a_event_held, evt.valid && evt.ready, evt_v_s1, "event lost")
	// a blocked item keeps its place and contents
	`MCC_ASSERT_NEXT(a_blocked_stays, evt_v_s1 && !s1_fire,
		evt_v_s1 && $stable(evt_s1), "blocked event changed")
	// a report is only produced when the output slot can take it
	`MCC_ASSERT_NOW(a_no_overwrite, s1_fire && has_result, out_free, "report overwritten")
endmodule

/* tb/sv/mouse_click_classifier_test.sv */
// ---------------------------------------------------------------------------
// mouse_click_classifier_test
// self-checking bench for the mouse click classifier: a short directed script
// of press, release, move and tick events, then randomised gesture sequences
// under several delay settings, each report checked against a written-out
// value or a cycle-free model of the click, double-click and hold rules
// ---------------------------------------------------------------------------
module mouse_click_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mcc_pkg::*;

	localparam int BUTTONS    = 8;
	localparam int SETTLE_CYC = 4;
	localparam int CYCLE_CAP  = 100000;
	localparam int CHOKE_CYC  = 300;

	// one line of the directed script
	typedef struct {
		evt_t ev;
		bit   typed;
		bit   has_rpt;
		rpt_t rpt;
	} row_t;

	logic clk;
	logic arst_n;

	mcc_evt_if evt();
	mcc_rpt_if rpt();
	mcc_cfg_if cfg();

	mouse_click_classifier #(
		.BUTTON_COUNT(BUTTONS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.evt   (evt),
		.rpt   (rpt),
		.cfg   (cfg)
	);

	// delay registers as seen by the model
	logic [DELAY_W-1:0] dbl_window;
	logic [DELAY_W-1:0] hold_window;

	// click tracking state of the model
	logic [BUTTONS-1:0] held_btns;
	logic [BUTTONS-1:0] dbl_btns;
	logic [BUTTONS-1:0] hold_btns;
	logic               click_armed;
	logic [BTN_W-1:0]   prev_button;
	logic [TIME_W-1:0]  click_start;
	logic [TIME_W-1:0]  quiet_since;

	rpt_t              expected_reports[$];
	row_t              script[$];
	int                error_count;
	int                items_accepted;
	int                cycle_count;
	int                snd_idle_pct;
	int                rcv_idle_pct;
	int                choke_left;
	bit                choke_request;
	logic [TIME_W-1:0] clock_now;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("mouse_click_classifier test failed");
			$finish;
		end
	end

	// work out the report an accepted event gives, and update the click state
	function automatic bit classify_event(input evt_t e, output rpt_t r);
		logic [BUTTONS-1:0] bmask;
		logic [BUTTONS-1:0] lmask;
		logic [TIME_W:0]    stamp;
		logic [TIME_W:0]    dbl_limit;
		logic [TIME_W:0]    hold_limit;
		bit                 made;
		bmask      = BUTTONS'(1) << e.button_number;
		lmask      = BUTTONS'(1) << prev_button;
		stamp      = {1'b0, e.time_stamp};
		// sums kept one bit wider so they never wrap
		dbl_limit  = {1'b0, click_start} + (TIME_W+1)'(dbl_window);
		hold_limit = {1'b0, quiet_since} + (TIME_W+1)'(hold_window);
		r          = '0;
		made       = 1'b0;
		case (e.command)
			CMD_PRESS: begin
				if (e.button_number < BUTTONS) begin
					// a press of a held button leaves the masks and the machine alone
					if ((held_btns & bmask) == '0) begin
						held_btns = held_btns | bmask;
						if (click_armed && e.button_number == prev_button &&
								stamp < dbl_limit) begin
							dbl_btns      = dbl_btns | bmask;
							r.double_mark = 1'b1;
						end else begin
							click_armed = 1'b0;
							click_start = e.time_stamp;
							prev_button = e.button_number;
						end
					end
					quiet_since       = e.time_stamp;
					r.report_kind     = RPT_PRESSED;
					r.reported_button = e.button_number;
					made              = 1'b1;
				end
			end
			CMD_RELEASE: begin
				if (e.button_number < BUTTONS) begin
					if (e.button_number == prev_button && !click_armed) begin
						click_armed = 1'b1;
					end else begin
						prev_button = '0;
						click_armed = 1'b0;
					end
					quiet_since       = e.time_stamp;
					r.report_kind     = RPT_RELEASED;
					r.reported_button = e.button_number;
					r.double_mark     = |(dbl_btns & bmask);
					r.hold_mark       = |(hold_btns & bmask);
					held_btns         = held_btns & ~bmask;
					dbl_btns          = dbl_btns & ~bmask;
					hold_btns         = hold_btns & ~bmask;
					made              = 1'b1;
				end
			end
			CMD_MOVE: begin
				click_armed = 1'b0;
				quiet_since = e.time_stamp;
			end
			CMD_TICK: begin
				// ticks only matter while the last button is down
				if ((held_btns & lmask) != '0) begin
					if (stamp > dbl_limit)
						click_armed = 1'b0;
					if (stamp > hold_limit) begin
						quiet_since       = e.time_stamp;
						hold_btns         = hold_btns | lmask;
						r.report_kind     = RPT_PRESSED;
						r.reported_button = prev_button;
						r.hold_mark       = 1'b1;
						made              = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return made;
	endfunction

	// script line with the report written out
	function automatic void known_row(input logic [CMD_W-1:0] cmd,
			input logic [TIME_W-1:0] t, input logic [BTN_W-1:0] b, input bit has,
			input logic kind, input logic [BTN_W-1:0] rb, input logic dbl,
			input logic hld);
		row_t row;
		row.ev                  = '{command: cmd, time_stamp: t, button_number: b};
		row.typed               = 1'b1;
		row.has_rpt             = has;
		row.rpt.report_kind     = kind;
		row.rpt.reported_button = rb;
		row.rpt.double_mark     = dbl;
		row.rpt.hold_mark       = hld;
		script.push_back(row);
	endfunction

	// script line checked against the model
	function automatic void open_row(input logic [CMD_W-1:0] cmd,
			input logic [TIME_W-1:0] t, input logic [BTN_W-1:0] b);
		row_t row;
		row.ev      = '{command: cmd, time_stamp: t, button_number: b};
		row.typed   = 1'b0;
		row.has_rpt = 1'b0;
		row.rpt     = '0;
		script.push_back(row);
	endfunction

	// moves the running time stamp on, now and then to a random point
	function automatic logic [TIME_W-1:0] next_stamp(input int unsigned span);
		if ($urandom_range(49) == 0)
			clock_now = $urandom;
		else
			clock_now = clock_now + $urandom_range(span);
		return clock_now;
	endfunction

	// offer one event item, wait for it to be taken, then log the expectation
	task automatic offer_event(input evt_t e, input bit typed, input bit t_has,
			input rpt_t t_rpt);
		rpt_t r;
		bit   made;
		while ($urandom_range(99) < snd_idle_pct) begin
			evt.valid <= 1'b0;
			@(posedge clk);
		end
		evt.valid         <= 1'b1;
		evt.command       <= e.command;
		evt.time_stamp    <= e.time_stamp;
		evt.button_number <= e.button_number;
		@(posedge clk);
		while (!evt.ready)
			@(posedge clk);
		made = classify_event(e, r);
		if (typed) begin
			made = t_has;
			r    = t_rpt;
		end
		if (made)
			expected_reports.push_back(r);
		items_accepted++;
	endtask

	task automatic send(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
			input logic [BTN_W-1:0] b);
		offer_event('{command: cmd, time_stamp: t, button_number: b}, 1'b0, 1'b0, '0);
	endtask

	// drop valid and let every report out before touching the registers
	task automatic settle();
		evt.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// write both delay registers, valid held high across the pair
	task automatic set_delays(input logic [DELAY_W-1:0] dbl, input logic [DELAY_W-1:0] hld);
		cfg.valid <= 1'b1;
		cfg.index <= REG_DOUBLE_DELAY;
		cfg.data  <= dbl;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		dbl_window = dbl;
		cfg.index <= REG_HOLD_DELAY;
		cfg.data  <= hld;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		hold_window = hld;
		cfg.valid <= 1'b0;
	endtask

	// random gestures: mostly well-formed clicks, double clicks, holds and chords
	task automatic run_gestures(input int count);
		int               target;
		int unsigned      dw;
		int unsigned      hw;
		int               pick;
		logic [BTN_W-1:0] b;
		logic [BTN_W-1:0] b2;
		target = items_accepted + count;
		dw     = 32'(dbl_window);
		hw     = 32'(hold_window);
		while (items_accepted < target) begin
			pick = $urandom_range(99);
			b    = BTN_W'($urandom_range(BUTTONS - 1));
			b2   = b + BTN_W'($urandom_range(1, BUTTONS - 1));
			if (pick < 25) begin
				// double click, gaps straddling the window
				send(CMD_PRESS, next_stamp(dw / 2 + 2), b);
				send(CMD_RELEASE, next_stamp(dw / 2 + 2), b);
				send(CMD_PRESS, next_stamp(dw / 2 + 2), b);
				send(CMD_RELEASE, next_stamp(dw + 2), b);
			end else if (pick < 45) begin
				// hold with ticks, sometimes a second button joins
				send(CMD_PRESS, next_stamp(4), b);
				repeat ($urandom_range(1, 4))
					send(CMD_TICK, next_stamp(hw / 2 + 2),
						BTN_W'($urandom_range(BUTTONS - 1)));
				if ($urandom_range(3) == 0)
					send(CMD_PRESS, next_stamp(hw / 2 + 2), b2);
				send(CMD_TICK, next_stamp(hw + 2), BTN_W'($urandom_range(BUTTONS - 1)));
				send(CMD_RELEASE, next_stamp(hw / 2 + 2), b);
			end else if (pick < 60) begin
				// chord, sometimes with a repeated press of a held button
				send(CMD_PRESS, next_stamp(dw / 2 + 2), b);
				send(CMD_PRESS, next_stamp(dw / 2 + 2), b2);
				if ($urandom_range(1) == 0)
					send(CMD_PRESS, next_stamp(dw / 2 + 2), b);
				if ($urandom_range(1) == 0) begin
					send(CMD_RELEASE, next_stamp(dw / 2 + 2), b);
					send(CMD_RELEASE, next_stamp(dw / 2 + 2), b2);
				end else begin
					send(CMD_RELEASE, next_stamp(dw / 2 + 2), b2);
					send(CMD_RELEASE, next_stamp(dw / 2 + 2), b);
				end
			end else if (pick < 70) begin
				// a move between two clicks breaks the double click
				send(CMD_PRESS, next_stamp(dw / 4 + 2), b);
				send(CMD_RELEASE, next_stamp(dw / 4 + 2), b);
				send(CMD_MOVE, next_stamp(dw / 4 + 2), BTN_W'($urandom_range(BUTTONS - 1)));
				send(CMD_PRESS, next_stamp(dw / 4 + 2), b);
				send(CMD_RELEASE, next_stamp(dw / 4 + 2), b);
			end else begin
				// noise
				send(CMD_W'($urandom_range(3)), next_stamp(2 * (dw > hw ? dw : hw) + 2), b);
			end
		end
	endtask

	// report sink ready, with an occasional long hold-off
	initial begin
		rpt.ready  = 1'b0;
		choke_left = 0;
		forever begin
			@(posedge clk);
			if (choke_request) begin
				choke_left    = CHOKE_CYC;
				choke_request = 1'b0;
			end
			if (choke_left > 0) begin
				rpt.ready <= 1'b0;
				choke_left--;
			end else begin
				rpt.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// compare each report item with the oldest expectation
	always @(posedge clk) begin : watch_reports
		rpt_t want;
		if (arst_n && rpt.valid && rpt.ready) begin
			if (expected_reports.size() == 0) begin
				$error("report with none expected: kind %0d button %0d double %0d hold %0d",
					rpt.report_kind, rpt.reported_button, rpt.double_mark, rpt.hold_mark);
				error_count++;
			end else begin
				want = expected_reports.pop_front();
				if (rpt.report_kind !== want.report_kind) begin
					$error("report_kind: expected %0d, got %0d", want.report_kind,
						rpt.report_kind);
					error_count++;
				end
				if (rpt.reported_button !== want.reported_button) begin
					$error("reported_button: expected %0d, got %0d", want.reported_button,
						rpt.reported_button);
					error_count++;
				end
				if (rpt.double_mark !== want.double_mark) begin
					$error("double_mark: expected %0d, got %0d", want.double_mark,
						rpt.double_mark);
					error_count++;
				end
				if (rpt.hold_mark !== want.hold_mark) begin
					$error("hold_mark: expected %0d, got %0d", want.hold_mark,
						rpt.hold_mark);
					error_count++;
				end
			end
		end
	end

	// reset, directed script, then the random phases
	initial begin : stimulus
		int i;
		arst_n            = 1'b0;
		evt.valid         = 1'b0;
		evt.command       = CMD_MOVE;
		evt.time_stamp    = '0;
		evt.button_number = '0;
		cfg.valid         = 1'b0;
		cfg.index         = REG_DOUBLE_DELAY;
		cfg.data          = '0;
		error_count       = 0;
		items_accepted    = 0;
		cycle_count       = 0;
		choke_request     = 1'b0;
		clock_now         = '0;
		snd_idle_pct      = 20;
		rcv_idle_pct      = 52;
		dbl_window        = DOUBLE_DELAY_RESET;
		hold_window       = HOLD_DELAY_RESET;
		held_btns         = '0;
		dbl_btns          = '0;
		hold_btns         = '0;
		click_armed       = 1'b0;
		prev_button       = '0;
		click_start       = '0;
		quiet_since       = '0;

		// idle tick and move, then a double click on button 0
		known_row(CMD_TICK, 0, 0, 0, RPT_PRESSED, 0, 0, 0);
		known_row(CMD_MOVE, 5, 4, 0, RPT_PRESSED, 0, 0, 0);
		known_row(CMD_PRESS, 10, 0, 1, RPT_PRESSED, 0, 0, 0);
		known_row(CMD_RELEASE, 20, 0, 1, RPT_RELEASED, 0, 0, 0);
		known_row(CMD_PRESS, 100, 0, 1, RPT_PRESSED, 0, 1, 0);
		// press of a button already held
		known_row(CMD_PRESS, 110, 0, 1, RPT_PRESSED, 0, 0, 0);
		known_row(CMD_RELEASE, 120, 0, 1, RPT_RELEASED, 0, 1, 0);
		// hold on button 7: tick exactly at the delay, then one past it
		known_row(CMD_PRESS, 200, 7, 1, RPT_PRESSED, 7, 0, 0);
		known_row(CMD_TICK, 1200, 2, 0, RPT_PRESSED, 0, 0, 0);
		known_row(CMD_TICK, 1201, 0, 1, RPT_PRESSED, 7, 0, 1);
		known_row(CMD_TICK, 1202, 0, 0, RPT_PRESSED, 0, 0, 0);
		known_row(CMD_RELEASE, 1300, 7, 1, RPT_RELEASED, 7, 0, 1);
		// double-click window edges: at the limit and one below
		open_row(CMD_PRESS, 1599, 7);
		open_row(CMD_RELEASE, 1600, 7);
		open_row(CMD_PRESS, 1899, 7);
		open_row(CMD_RELEASE, 1900, 7);
		open_row(CMD_PRESS, 2198, 7);
		// other button pressed, release of a button that is not the last
		open_row(CMD_PRESS, 2199, 3);
		open_row(CMD_RELEASE, 2200, 7);
		open_row(CMD_MOVE, 2201, 1);
		open_row(CMD_RELEASE, 2202, 3);
		// time sums near the top of the range must not wrap
		open_row(CMD_PRESS, 32'hFFFF_FF00, 5);
		known_row(CMD_TICK, 32'hFFFF_FFFF, 5, 0, RPT_PRESSED, 0, 0, 0);
		open_row(CMD_RELEASE, 32'hFFFF_FFFF, 5);
		open_row(CMD_PRESS, 0, 5);
		open_row(CMD_RELEASE, 0, 5);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < script.size(); i++)
			offer_event(script[i].ev, script[i].typed, script[i].has_rpt, script[i].rpt);
		settle();

		// short windows, sender idles little, receiver a lot
		set_delays(40, 60);
		run_gestures(250);
		settle();

		// zero delays, idling the other way round
		snd_idle_pct = 52;
		rcv_idle_pct = 20;
		set_delays(16'd0, 16'd0);
		run_gestures(150);
		settle();

		// widest delays, no idling
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_delays(16'hFFFF, 16'hFFFF);
		run_gestures(150);
		settle();

		// receiver stops for a long stretch while events keep coming
		set_delays(25, 100);
		run_gestures(120);
		choke_request = 1'b1;
		run_gestures(130);
		settle();
		repeat (SETTLE_CYC) @(posedge clk);

		if (error_count == 0 && expected_reports.size() == 0) begin
			$display("mouse_click_classifier test passed");
		end else begin
			$display("mouse_click_classifier test failed");
		end
		$finish;
	end

endmodule
